>>> rtl/xss_pkg.sv
// shared types and constants of the xorshift-star random source
package xss_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int OP_W   = 3;

    localparam logic [WORD_W-1:0] START_WORD = 64'd4101842887655102017;
    localparam logic [WORD_W-1:0] MULTIPLIER = 64'd2685821657736338717;

    localparam int SHIFT_A = 21;
    localparam int SHIFT_B = 35;
    localparam int SHIFT_C = 4;

    localparam logic [OP_W-1:0] OP_WORD64 = 3'd0;
    localparam logic [OP_W-1:0] OP_WORD32 = 3'd1;
    localparam logic [OP_W-1:0] OP_HALF16 = 3'd2;
    localparam logic [OP_W-1:0] OP_BYTE8  = 3'd3;
    localparam logic [OP_W-1:0] OP_RANGE  = 3'd4;

    localparam logic [1:0] MUL_LO_LO = 2'd0;
    localparam logic [1:0] MUL_LO_HI = 2'd1;
    localparam logic [1:0] MUL_HI_LO = 2'd2;
    localparam logic [1:0] MUL_LAST  = MUL_HI_LO;

    localparam int CNT_W    = 6;
    localparam int DIV_BITS = WORD_W;

    localparam logic [1:0] HALF_FULL = 2'd3;
    localparam logic [2:0] BYTE_FULL = 3'd7;

    typedef struct packed {
        logic       capture;
        logic       mix_seed;
        logic       mix_draw;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       load_word;
        logic       div_init;
        logic       div_step;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            seeded;
        logic            half_empty;
        logic            byte_empty;
        logic            span_zero;
    } t_stat;

endpackage

>>> rtl/xss_ctrl.sv
// sequencer for seeding, draw, multiply, divide and result beat
module xss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  xss_pkg::t_stat   i_stat,
    output xss_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_MIX    = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_LOADW  = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    localparam logic [xss_pkg::CNT_W-1:0] DIV_LAST = xss_pkg::CNT_W'(xss_pkg::DIV_BITS - 1);

    logic [2:0]                r_state, n_state;
    logic [xss_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_fold, n_fold;
    logic                      r_out_valid, n_out_valid;
    logic                      narrow_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    assign narrow_ready = (i_stat.op == xss_pkg::OP_HALF16 && !i_stat.half_empty) ||
                          (i_stat.op == xss_pkg::OP_BYTE8 && !i_stat.byte_empty);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_fold      = r_fold;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.op > xss_pkg::OP_RANGE) begin
                    n_state = S_FIN;
                end else if (!i_stat.seeded) begin
                    o_cmd.mix_seed = 1'b1;
                    n_fold         = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_MUL;
                end else if (narrow_ready) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                o_cmd.mix_draw = 1'b1;
                n_fold         = 1'b0;
                n_cnt          = '0;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = r_cnt[1:0];
                if (r_cnt[1:0] == xss_pkg::MUL_LAST) begin
                    n_cnt = '0;
                    if (r_fold) begin
                        n_state = S_LOADW;
                    end else if (i_stat.op == xss_pkg::OP_RANGE && !i_stat.span_zero) begin
                        o_cmd.div_init = 1'b1;
                        n_state        = S_DIV;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_LOADW: begin
                o_cmd.load_word = 1'b1;
                n_state         = S_DECIDE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_fold      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fold      <= n_fold;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken beat");

    a_mul_starts_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX) |=> (r_state == S_MUL && r_cnt == '0))
        else $error("multiply sequence did not start at step zero");

    a_div_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && $past(r_state) != S_DIV) |-> ($past(r_state) == S_MUL && r_cnt == '0))
        else $error("divide entered without a finished draw");
`endif

endmodule

>>> rtl/xss_dp.sv
// generator state, shared multiplier, restoring divider and result register
module xss_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  xss_pkg::t_cmd                 i_cmd,
    output xss_pkg::t_stat                o_stat,
    input  logic [xss_pkg::OP_W-1:0]      i_operation,
    input  logic [xss_pkg::WORD_W-1:0]    i_range_min,
    input  logic [xss_pkg::WORD_W-1:0]    i_range_max,
    input  logic                          i_cfg_valid,
    input  logic [xss_pkg::WORD_W-1:0]    i_cfg_seed,
    output logic [xss_pkg::WORD_W-1:0]    o_value,
    output logic                          o_range_error
);

    localparam int W = xss_pkg::WORD_W;
    localparam int H = xss_pkg::HALF_W;

    function automatic logic [W-1:0] shift_mix(input logic [W-1:0] w);
        logic [W-1:0] t;
        t = w ^ (w >> xss_pkg::SHIFT_A);
        t = t ^ (t << xss_pkg::SHIFT_B);
        t = t ^ (t >> xss_pkg::SHIFT_C);
        return t;
    endfunction

    logic [W-1:0]              r_seed;
    logic [W-1:0]              r_word;
    logic                      r_seeded;
    logic [W-1:0]              r_half;
    logic [1:0]                r_half_cnt;
    logic [W-1:0]              r_byte;
    logic [2:0]                r_byte_cnt;

    logic [xss_pkg::OP_W-1:0]  r_op;
    logic [W-1:0]              r_min;
    logic [W-1:0]              r_span;
    logic [W-1:0]              r_acc;
    logic [W-1:0]              r_rem;
    logic [W-1:0]              r_value;
    logic                      r_err;

    logic [H-1:0]              mul_a;
    logic [H-1:0]              mul_b;
    logic [W-1:0]              mul_p;
    logic [W:0]                rem_sh;
    logic [W:0]                rem_diff;
    logic [W-1:0]              half_next;
    logic [W-1:0]              byte_next;
    logic [W-1:0]              n_value;
    logic                      n_err;

    assign o_stat.op         = r_op;
    assign o_stat.seeded     = r_seeded;
    assign o_stat.half_empty = (r_half_cnt == 2'd0);
    assign o_stat.byte_empty = (r_byte_cnt == 3'd0);
    assign o_stat.span_zero  = (r_span == '0);

    assign o_value       = r_value;
    assign o_range_error = r_err;

    // low-half products only matter for a product kept modulo 2^64
    assign mul_a = (i_cmd.mul_step == xss_pkg::MUL_HI_LO) ? r_word[W-1:H] : r_word[H-1:0];
    assign mul_b = (i_cmd.mul_step == xss_pkg::MUL_LO_HI) ? xss_pkg::MULTIPLIER[W-1:H]
                                                          : xss_pkg::MULTIPLIER[H-1:0];
    assign mul_p = {{H{1'b0}}, mul_a} * {{H{1'b0}}, mul_b};

    assign rem_sh   = {r_rem, r_acc[W-1]};
    assign rem_diff = rem_sh - {1'b0, r_span};

    assign half_next = (r_half_cnt != 2'd0) ? (r_half >> 16) : r_acc;
    assign byte_next = (r_byte_cnt != 3'd0) ? (r_byte >> 8) : r_acc;

    always_comb begin
        n_value = '0;
        n_err   = 1'b0;
        case (r_op)
            xss_pkg::OP_WORD64: n_value = r_acc;
            xss_pkg::OP_WORD32: n_value = {{H{1'b0}}, r_acc[H-1:0]};
            xss_pkg::OP_HALF16: n_value = {{(W-16){1'b0}}, half_next[15:0]};
            xss_pkg::OP_BYTE8:  n_value = {{(W-8){1'b0}}, byte_next[7:0]};
            xss_pkg::OP_RANGE: begin
                if (r_span == '0) begin
                    n_value = r_min;
                    n_err   = 1'b1;
                end else begin
                    n_value = r_min + r_rem;
                end
            end
            default: n_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_word     <= xss_pkg::START_WORD;
            r_seeded   <= 1'b0;
            r_half     <= '0;
            r_half_cnt <= '0;
            r_byte     <= '0;
            r_byte_cnt <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_seed;
            end
            if (i_cmd.mix_seed) begin
                r_word <= shift_mix(r_word ^ r_seed);
            end else if (i_cmd.mix_draw) begin
                r_word <= shift_mix(r_word);
            end else if (i_cmd.load_word) begin
                r_word   <= r_acc;
                r_seeded <= 1'b1;
            end
            if (i_cmd.finish && r_op == xss_pkg::OP_HALF16) begin
                r_half     <= half_next;
                r_half_cnt <= (r_half_cnt != 2'd0) ? r_half_cnt - 2'd1 : xss_pkg::HALF_FULL;
            end
            if (i_cmd.finish && r_op == xss_pkg::OP_BYTE8) begin
                r_byte     <= byte_next;
                r_byte_cnt <= (r_byte_cnt != 3'd0) ? r_byte_cnt - 3'd1 : xss_pkg::BYTE_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_min  <= i_range_min;
            r_span <= i_range_max - i_range_min;
        end
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_step == xss_pkg::MUL_LO_LO) begin
                r_acc <= mul_p;
            end else begin
                r_acc[W-1:H] <= r_acc[W-1:H] + mul_p[H-1:0];
            end
        end else if (i_cmd.div_step) begin
            r_acc <= {r_acc[W-2:0], 1'b0};
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_diff[W] ? rem_sh[W-1:0] : rem_diff[W-1:0];
        end
        if (i_cmd.finish) begin
            r_value <= n_value;
            r_err   <= n_err;
        end
    end

`ifndef SYNTHESIS
    a_seeded_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_word |=> r_seeded)
        else $error("seed fold did not mark the generator as started");

    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.div_step) |-> (r_rem < r_span))
        else $error("partial remainder reached the divisor");
`endif

endmodule

>>> rtl/xorshift_star_random_source.sv
// a fresh 64-bit draw steps through these states in order:
// decode, mix, three 32x32 partial products on one shared multiplier, result load
// ranged draw with a nonzero span then runs the restoring divider, one quotient bit per cycle
// narrow draw served from a reserve word, or an unknown operation, skips mix and multiply
// one request at a time, next input beat once the result loads; first also folds in the seed
// synchronous active-low reset restores the start word and empties both reserves
module xorshift_star_random_source (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [xss_pkg::OP_W-1:0]      i_operation,
    input  logic [xss_pkg::WORD_W-1:0]    i_range_min,
    input  logic [xss_pkg::WORD_W-1:0]    i_range_max,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [xss_pkg::WORD_W-1:0]    o_value,
    output logic                          o_range_error,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [xss_pkg::WORD_W-1:0]    i_cfg_seed
);

    xss_pkg::t_cmd  cmd;
    xss_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    xss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    xss_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_range_min   (i_range_min),
        .i_range_max   (i_range_max),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_seed    (i_cfg_seed),
        .o_value       (o_value),
        .o_range_error (o_range_error)
    );

endmodule
